// ===== rtl/rfifo_pkg.sv =====
// ----------------------------------------------------------------------------
// rfifo_pkg
// Shared types and constants of the ring FIFO with peek and skip: request
// kinds, status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package rfifo_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Capacity after reset, before it is clamped to the actual depth.
  localparam int CAP_RESET = 64;

  // Widths of the stream fields.
  localparam int KIND_W   = 3;
  localparam int ITEM_W   = 32;
  localparam int AMOUNT_W = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Register map, in word addresses.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH      = 3'd0,
    KIND_POP       = 3'd1,
    KIND_PEEK      = 3'd2,
    KIND_PEEK_AT   = 3'd3,
    KIND_DROP      = 3'd4,
    KIND_FLUSH     = 3'd5,
    KIND_OVERWRITE = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/ring_fifo_with_peek_and_skip.sv =====
// ----------------------------------------------------------------------------
// ring_fifo_with_peek_and_skip
// Ring-buffer FIFO with push, pop, peek, peek at an offset, drop, flush and
// overwrite requests, each answered with a status, read data and counts.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while s_tready is high and
// returns one result for each: the pointers and counts are updated at
// acceptance, and the entry read comes out of a synchronous memory with a
// separate write port and a registered read, followed by the output
// register. A result that waits on the output holds up only one request
// behind it. Writing the capacity register empties the FIFO at once; it must
// be written only while no request is in flight. Only bits [6:0] of a written
// capacity are kept; a kept zero reads as one, and above DEPTH reads as DEPTH.
module ring_fifo_with_peek_and_skip
  import rfifo_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] item_data, [38:32] amount, [39] zero
  input  logic [2:0]  s_tuser,   // [2:0] kind
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] read_data, [38:32] readable_count,
                                 // [45:39] writable_count, [47:46] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  // Working width for count arithmetic: holds a sum of two values below
  // twice the larger of the depth and the amount field.
  localparam int WW = ((CW > AMOUNT_W) ? CW : AMOUNT_W) + 1;
  localparam int XW = (DATA_WIDTH > ITEM_W) ? DATA_WIDTH : ITEM_W;
  localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  // Pointer and capacity state.
  logic [PW-1:0]         head, head_next;
  logic [PW-1:0]         tail, tail_next;
  logic                  full, full_next;
  logic [CW-1:0]         cap;

  // Entry memory.
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [PW-1:0]         mem_raddr;
  logic                  mem_we;
  logic                  mem_re;
  logic [XW-1:0]         din_ext;
  logic [XW-1:0]         rd_ext;

  // Read stage.
  logic                  p_valid;
  status_t               p_status;
  logic                  p_rd_use;
  logic [COUNT_W-1:0]    p_rcnt;
  logic [COUNT_W-1:0]    p_wcnt;

  // Request decode.
  kind_t                 kind;
  logic [ITEM_W-1:0]     item_data;
  logic [AMOUNT_W-1:0]   amount;
  logic                  accept;
  logic                  p_adv;
  status_t               status_c;
  logic                  rd_use_c;

  // Count arithmetic.
  logic [WW-1:0]         cap_w, head_w, tail_w, amt_w, cnt_w, after_w, wcnt_w;
  logic [WW-1:0]         head_inc, tail_inc, head_amt;

  // Configuration.
  logic                  cfg_we;
  logic [WW-1:0]         cfg_val;
  logic [WW-1:0]         cfg_clamped;

  function automatic logic [WW-1:0] wrap_add(input logic [WW-1:0] base,
                                             input logic [WW-1:0] step,
                                             input logic [WW-1:0] limit);
    logic [WW-1:0] s;
    s = base + step;
    if (s >= limit) begin
      s = s - limit;
    end
    return s;
  endfunction

  assign kind      = kind_t'(s_tuser);
  assign item_data = s_tdata[ITEM_W-1:0];
  assign amount    = s_tdata[ITEM_W +: AMOUNT_W];

  assign p_adv    = p_valid && (!m_tvalid || m_tready);
  assign s_tready = !p_valid || p_adv;
  assign accept   = s_tvalid && s_tready;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign cfg_val = WW'(pwdata[AMOUNT_W-1:0]);

  always_comb begin
    cfg_clamped = cfg_val;
    if (cfg_val == '0) begin
      cfg_clamped = WW'(1);
    end else if (cfg_val > WW'(DEPTH)) begin
      cfg_clamped = WW'(DEPTH);
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap) : 32'd0;

  // --------------------------------------------------------------- counts
  assign cap_w  = WW'(cap);
  assign head_w = WW'(head);
  assign tail_w = WW'(tail);
  assign amt_w  = WW'(amount);

  always_comb begin
    if (full) begin
      cnt_w = cap_w;
    end else if (tail_w >= head_w) begin
      cnt_w = tail_w - head_w;
    end else begin
      cnt_w = tail_w + cap_w - head_w;
    end
  end

  assign head_inc = wrap_add(head_w, WW'(1), cap_w);
  assign tail_inc = wrap_add(tail_w, WW'(1), cap_w);
  assign head_amt = wrap_add(head_w, amt_w, cap_w);

  // --------------------------------------------------------- request logic
  always_comb begin
    head_next = head;
    tail_next = tail;
    full_next = full;
    status_c  = ST_OK;
    rd_use_c  = 1'b0;
    after_w   = cnt_w;
    mem_we    = 1'b0;
    mem_raddr = head;
    case (kind)
      KIND_PUSH: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          tail_next = tail_inc[PW-1:0];
          full_next = (tail_inc == head_w);
          after_w   = cnt_w + WW'(1);
        end
      end
      KIND_POP: begin
        if (cnt_w == '0) begin
          status_c = ST_EMPTY;
        end else begin
          rd_use_c  = 1'b1;
          head_next = head_inc[PW-1:0];
          full_next = 1'b0;
          after_w   = cnt_w - WW'(1);
        end
      end
      KIND_PEEK: begin
        if (cnt_w == '0) begin
          status_c = ST_EMPTY;
        end else begin
          rd_use_c = 1'b1;
        end
      end
      KIND_PEEK_AT: begin
        if (amt_w >= cnt_w) begin
          status_c = ST_EMPTY;
        end else begin
          rd_use_c  = 1'b1;
          mem_raddr = head_amt[PW-1:0];
        end
      end
      KIND_DROP: begin
        if (amt_w == '0) begin
          status_c = ST_OK;
        end else if (amt_w > cnt_w) begin
          status_c = ST_EMPTY;
        end else begin
          head_next = head_amt[PW-1:0];
          full_next = 1'b0;
          after_w   = cnt_w - amt_w;
        end
      end
      KIND_FLUSH: begin
        head_next = tail;
        full_next = 1'b0;
        after_w   = '0;
      end
      KIND_OVERWRITE: begin
        // Flush, then push into the now empty ring; full only at capacity one.
        mem_we    = 1'b1;
        head_next = tail;
        tail_next = tail_inc[PW-1:0];
        full_next = (tail_inc == tail_w);
        after_w   = WW'(1);
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  assign wcnt_w = cap_w - after_w;
  assign mem_re = accept && rd_use_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      full <= 1'b0;
      cap  <= CW'(CAP_RST);
    end else if (cfg_we) begin
      head <= '0;
      tail <= '0;
      full <= 1'b0;
      cap  <= cfg_clamped[CW-1:0];
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
      full <= full_next;
    end
  end

  // --------------------------------------------------------------- memory
  assign din_ext = XW'(item_data);

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[tail] <= din_ext[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // ----------------------------------------------------------- read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status <= status_c;
      p_rd_use <= rd_use_c;
      p_rcnt   <= after_w[COUNT_W-1:0];
      p_wcnt   <= wcnt_w[COUNT_W-1:0];
    end
  end

  // --------------------------------------------------------- output stage
  assign rd_ext = XW'(mem_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      m_tuser <= p_status;
      m_tdata <= {2'b00, p_wcnt, p_rcnt,
                  p_rd_use ? rd_ext[ITEM_W-1:0] : {ITEM_W{1'b0}}};
    end
  end

  // ----------------------------------------------------------- assertions
  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    (cap != '0) && (cap <= CW'(DEPTH)))
    else $error("capacity out of range");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (head_w < cap_w) && (tail_w < cap_w))
    else $error("pointer beyond capacity");

  a_full_meet: assert property (@(posedge clk) disable iff (rst)
    full |-> (head == tail))
    else $error("full mark set with head and tail apart");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (p_valid && m_tvalid && !m_tready))
    else $error("request stalled without a blocked result");

  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[ITEM_W-1:0] == '0))
    else $error("read data on a failed request");

endmodule

// ===== tb/tb_ring_fifo_with_peek_and_skip.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_fifo_with_peek_and_skip
// Self-checking regression for the ring FIFO with peek and skip. Requests go
// in on the slave stream with random gaps, and results are taken off the
// master stream with random stalls. A shadow FIFO works out each result when
// its request transaction is seen, and every result transaction is compared
// with the oldest expected one. Capacity is reprogrammed between phases,
// including the clamped extremes.
// ----------------------------------------------------------------------------
module tb_ring_fifo_with_peek_and_skip;
  import rfifo_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int MAX_REPORTS    = 10;
  localparam int RESULT_LATENCY = 2;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 140;

  typedef struct {
    status_t              status;
    logic [ITEM_W-1:0]    read_data;
    logic [COUNT_W-1:0]   readable;
    logic [COUNT_W-1:0]   writable;
  } fifo_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // [31:0] item_data, [38:32] amount, [39] zero
  logic [2:0]  s_tuser  = '0;   // [2:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // [31:0] read_data, [38:32] readable_count,
                                // [45:39] writable_count, [47:46] zero
  logic [1:0]  m_tuser;         // [1:0] status
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the FIFO contents and pointers.
  logic [ITEM_W-1:0] shadow_mem [DEPTH_DEF];
  int unsigned       shadow_head;
  int unsigned       shadow_tail;
  int unsigned       shadow_cap;
  bit                shadow_full;
  fifo_result_t      expected_results[$];

  bit          source_idle     = 1'b1;
  bit          sink_idle       = 1'b1;
  int          sink_hold       = 0;
  int unsigned capacity_now    = 64;
  int          failure_count   = 0;
  int          requests_sent   = 0;
  int          results_checked = 0;
  int          capacity_writes = 0;

  ring_fifo_with_peek_and_skip u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("ring_fifo_with_peek_and_skip regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- shadow FIFO

  function automatic int unsigned held_items();
    if (shadow_full)
      return shadow_cap;
    if (shadow_tail >= shadow_head)
      return shadow_tail - shadow_head;
    return shadow_tail + shadow_cap - shadow_head;
  endfunction

  function automatic int unsigned ring_next(int unsigned base, int unsigned step);
    int unsigned sum;
    sum = base + step;
    if (sum >= shadow_cap)
      sum -= shadow_cap;
    return sum;
  endfunction

  function automatic status_t push_entry(logic [ITEM_W-1:0] data);
    if (shadow_full)
      return ST_FULL;
    shadow_mem[shadow_tail] = data;
    shadow_tail = ring_next(shadow_tail, 1);
    if (shadow_tail == shadow_head)
      shadow_full = 1'b1;
    return ST_OK;
  endfunction

  function automatic fifo_result_t apply_request(logic [KIND_W-1:0] kind,
                                                 logic [ITEM_W-1:0] data,
                                                 logic [AMOUNT_W-1:0] amount);
    fifo_result_t res;
    int unsigned  held;
    held = held_items();
    res.status    = ST_OK;
    res.read_data = '0;
    case (kind)
      KIND_PUSH: res.status = push_entry(data);
      KIND_POP: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_data = shadow_mem[shadow_head];
          shadow_head = ring_next(shadow_head, 1);
          shadow_full = 1'b0;
        end
      end
      KIND_PEEK: begin
        if (held == 0)
          res.status = ST_EMPTY;
        else
          res.read_data = shadow_mem[shadow_head];
      end
      KIND_PEEK_AT: begin
        if (amount >= held)
          res.status = ST_EMPTY;
        else
          res.read_data = shadow_mem[ring_next(shadow_head, amount)];
      end
      KIND_DROP: begin
        // A drop of zero is a no-op that still reports ok.
        if (amount > held) begin
          res.status = ST_EMPTY;
        end else if (amount != 0) begin
          shadow_head = ring_next(shadow_head, amount);
          shadow_full = 1'b0;
        end
      end
      KIND_FLUSH: begin
        shadow_head = shadow_tail;
        shadow_full = 1'b0;
      end
      KIND_OVERWRITE: begin
        shadow_head = shadow_tail;
        shadow_full = 1'b0;
        res.status  = push_entry(data);
      end
      default: ;
    endcase
    held = held_items();
    res.readable = COUNT_W'(held);
    res.writable = COUNT_W'(shadow_cap - held);
    return res;
  endfunction

  function automatic void report_failure(string msg);
    failure_count++;
    if (failure_count <= MAX_REPORTS)
      $display("%s", msg);
  endfunction

  // Everything is observed at the rising edge, in one place, so that the
  // capacity write, the request and the result of one cycle are handled in a
  // fixed order.
  always @(posedge clk) begin : scoreboard
    fifo_result_t got;
    fifo_result_t want;
    int unsigned  cap_value;
    if (rst) begin
      shadow_head = 0;
      shadow_tail = 0;
      shadow_full = 1'b0;
      shadow_cap  = (CAP_RESET > DEPTH_DEF) ? DEPTH_DEF : CAP_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
        cap_value = pwdata[6:0];
        if (cap_value == 0)
          cap_value = 1;
        if (cap_value > DEPTH_DEF)
          cap_value = DEPTH_DEF;
        shadow_cap  = cap_value;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_full = 1'b0;
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_request(s_tuser, s_tdata[31:0],
                                                 s_tdata[38:32]));
      if (m_tvalid && m_tready) begin
        got.status    = status_t'(m_tuser);
        got.read_data = m_tdata[31:0];
        got.readable  = m_tdata[38:32];
        got.writable  = m_tdata[45:39];
        results_checked++;
        if (expected_results.size() == 0) begin
          report_failure($sformatf("unexpected result: status %0d data %h rd %0d wr %0d",
                                   got.status, got.read_data, got.readable,
                                   got.writable));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.read_data !== want.read_data ||
              got.readable !== want.readable || got.writable !== want.writable)
            report_failure({
              $sformatf("mismatch at result %0d: expected status %0d data %h rd %0d wr %0d",
                        results_checked, want.status, want.read_data,
                        want.readable, want.writable),
              $sformatf(", got status %0d data %h rd %0d wr %0d",
                        got.status, got.read_data, got.readable, got.writable)});
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Result side: a random stall before each transaction while sink_idle is
  // set, plus a long hold-off whenever a test asks for one.
  always begin : sink_side
    int stall;
    @(negedge clk);
    if (sink_hold > 0) begin
      m_tready = 1'b0;
      repeat (sink_hold) @(negedge clk);
      sink_hold = 0;
    end
    stall = sink_idle ? $urandom_range(0, 5) : 0;
    if (stall > 0) begin
      m_tready = 1'b0;
      repeat (stall) @(negedge clk);
    end
    m_tready = 1'b1;
    do @(posedge clk); while (!m_tvalid);
  end

  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [ITEM_W-1:0] data,
                              input logic [AMOUNT_W-1:0] amount);
    int gap;
    gap = source_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {1'b0, amount, data};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
  endtask

  // Stops offering requests and waits until every result is back, then lets
  // the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] value);
    drain_results();
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {REG_CAPACITY, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    capacity_now = (value[6:0] == 0) ? 1 :
                   (value[6:0] > DEPTH_DEF) ? DEPTH_DEF : value[6:0];
    capacity_writes++;
  endtask

  // ---------------------------------------------------------------- tests

  // Empty-buffer refusals, the no-op drop, the unused kind, data extremes,
  // offset bounds, partial and complete drops, flush and overwrite.
  task automatic test_directed_requests();
    send_request(KIND_POP, $urandom, 0);
    send_request(KIND_PEEK, $urandom, 0);
    send_request(KIND_PEEK_AT, $urandom, 0);
    send_request(KIND_DROP, $urandom, 0);
    send_request(KIND_DROP, $urandom, 1);
    send_request(KIND_UNUSED, $urandom, 7'd64);
    send_request(KIND_PUSH, 32'h0000_0000, 0);
    send_request(KIND_PUSH, 32'hFFFF_FFFF, 7'd64);
    send_request(KIND_PUSH, 32'hA5A5_A5A5, 0);
    send_request(KIND_PUSH, 32'h5A5A_5A5A, 0);
    send_request(KIND_PEEK, $urandom, 0);
    send_request(KIND_PEEK_AT, $urandom, 3);
    send_request(KIND_PEEK_AT, $urandom, 4);
    send_request(KIND_PEEK_AT, $urandom, 7'd64);
    send_request(KIND_POP, $urandom, 0);
    send_request(KIND_DROP, $urandom, 5);
    send_request(KIND_DROP, $urandom, 2);
    send_request(KIND_DROP, $urandom, 1);
    send_request(KIND_PUSH, 32'h1234_5678, 0);
    send_request(KIND_FLUSH, $urandom, 0);
    send_request(KIND_OVERWRITE, 32'hDEAD_BEEF, 0);
    send_request(KIND_PEEK, $urandom, 0);
    send_request(KIND_UNUSED, $urandom, 0);
  endtask

  // Smallest capacity, a zero write that clamps up, an oversized write that
  // clamps down, then a full-depth fill with wrap-around.
  task automatic test_capacity_limits();
    write_capacity(1);
    send_request(KIND_PUSH, $urandom, 0);
    send_request(KIND_PUSH, $urandom, 0);
    send_request(KIND_PEEK_AT, $urandom, 0);
    send_request(KIND_OVERWRITE, $urandom, 0);
    send_request(KIND_POP, $urandom, 0);
    send_request(KIND_POP, $urandom, 0);
    send_request(KIND_OVERWRITE, $urandom, 0);
    send_request(KIND_DROP, $urandom, 1);
    write_capacity(0);
    send_request(KIND_PUSH, $urandom, 0);
    send_request(KIND_PUSH, $urandom, 0);
    write_capacity(127);
    repeat (64) send_request(KIND_PUSH, $urandom, 0);
    send_request(KIND_PUSH, $urandom, 0);
    send_request(KIND_PEEK_AT, $urandom, 63);
    send_request(KIND_PEEK_AT, $urandom, 7'd64);
    send_request(KIND_DROP, $urandom, 7'd64);
    repeat (40) send_request(KIND_PUSH, $urandom, 0);
    repeat (30) send_request(KIND_POP, $urandom, 0);
    repeat (54) send_request(KIND_PUSH, $urandom, 0);
    send_request(KIND_PEEK_AT, $urandom, AMOUNT_W'($urandom_range(0, 63)));
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the block backs up and drops s_tready; afterwards the sender waits for
  // every result before it goes on.
  task automatic test_backpressure();
    int i;
    write_capacity(16);
    source_idle = 1'b0;
    sink_hold   = 200;
    for (i = 0; i < 50; i++)
      send_request((i % 3 == 2) ? KIND_POP : KIND_PUSH, $urandom, 0);
    drain_results();
    source_idle = 1'b1;
    for (i = 0; i < 10; i++)
      send_request(KIND_PEEK_AT, $urandom, AMOUNT_W'($urandom_range(0, 16)));
  endtask

  task automatic test_random_traffic();
    int unsigned       cap_list [RANDOM_PHASES] = '{2, 3, 5, 64, 1, 17, 33, 63, 0};
    int                phase;
    int                i;
    int                pick;
    bit                filling;
    logic [KIND_W-1:0] kind;
    logic [AMOUNT_W-1:0] amount;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_capacity(cap_list[phase] != 0 ? cap_list[phase] : $urandom_range(1, 64));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // Every 35 requests a new burst picks at random between filling and draining,
        // and between idle gaps and back-to-back traffic.
        if (i % 35 == 0) begin
          filling     = ($urandom_range(0, 1) != 0);
          source_idle = ($urandom_range(0, 3) != 0);
          sink_idle   = ($urandom_range(0, 3) != 0);
        end
        pick = $urandom_range(0, 99);
        if (filling)
          kind = (pick < 55) ? KIND_PUSH : (pick < 65) ? KIND_POP :
                 (pick < 73) ? KIND_PEEK : (pick < 85) ? KIND_PEEK_AT :
                 (pick < 93) ? KIND_DROP : (pick < 96) ? KIND_FLUSH : KIND_OVERWRITE;
        else
          kind = (pick < 20) ? KIND_PUSH : (pick < 50) ? KIND_POP :
                 (pick < 58) ? KIND_PEEK : (pick < 72) ? KIND_PEEK_AT :
                 (pick < 92) ? KIND_DROP : (pick < 95) ? KIND_FLUSH : KIND_OVERWRITE;
        case ($urandom_range(0, 3))
          0:       amount = AMOUNT_W'($urandom_range(0, 64));
          1:       amount = AMOUNT_W'($urandom_range(0, capacity_now));
          default: amount = AMOUNT_W'($urandom_range(0, 3));
        endcase
        send_request(kind, $urandom, amount);
      end
    end
    source_idle = 1'b1;
    sink_idle   = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_requests();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (8) @(negedge clk);
    $display("Sent %0d requests and checked %0d results across %0d capacity writes,",
             requests_sent, results_checked, capacity_writes);
    $display("covering empty, full, wrap-around, clamped capacity and output back-pressure.");
    if (failure_count == 0)
      $display("ring_fifo_with_peek_and_skip regression: pass");
    else
      $display("ring_fifo_with_peek_and_skip regression: fail");
    $finish;
  end

endmodule
